// File: hw/rtl/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
// Used by deq_ptr and double_ended_queue_core. It has no dependencies.
package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // Operation codes carried by the action field.
    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_INJECT = 2'd2,
        ACT_EJECT  = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Decoded operation: memory access plus the result that goes with it.
    typedef struct packed {
        logic    mem_we;
        logic    mem_re;
        addr_t   addr;
        status_t status;
        cnt_t    count;
    } op_t;

    localparam addr_t LAST_IDX = addr_t'(DEPTH - 1);
    localparam cnt_t  FULL_CNT = cnt_t'(DEPTH);

    // Ring index one step forward, wrapping at the last slot.
    function automatic addr_t idx_next(input addr_t i);
        return (i == LAST_IDX) ? '0 : addr_t'(i + addr_t'(1));
    endfunction

    // Ring index one step back, wrapping at slot zero.
    function automatic addr_t idx_prev(input addr_t i);
        return (i == '0) ? LAST_IDX : addr_t'(i - addr_t'(1));
    endfunction

endpackage

// File: hw/rtl/deq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stands alone; the read data holds until the next read enable.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/deq_ptr.sv
// Front and rear ring pointers and the fill count of the deque.
// Decodes each operation into a memory access and its status. Uses deq_pkg.
module deq_ptr (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  deq_pkg::action_t act,
    output deq_pkg::op_t     op
);
    import deq_pkg::*;

    addr_t front_reg, front_next;
    addr_t rear_reg,  rear_next;
    cnt_t  count_reg, count_next;
    addr_t front_dec;
    addr_t rear_dec;

    assign front_dec = idx_prev(front_reg);
    assign rear_dec  = idx_prev(rear_reg);

    // Decode the operation against the current pointers and count.
    always_comb
    begin
        op.mem_we  = 1'b0;
        op.mem_re  = 1'b0;
        op.addr    = front_reg;
        op.status  = ST_OK;
        op.count   = count_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        case (act)
            ACT_PUSH:
            begin
                if (count_reg == FULL_CNT)
                begin
                    op.status = ST_FULL;
                end
                else
                begin
                    op.mem_we  = 1'b1;
                    op.addr    = front_dec;
                    front_next = front_dec;
                    op.count   = cnt_t'(count_reg + cnt_t'(1));
                end
            end
            ACT_INJECT:
            begin
                if (count_reg == FULL_CNT)
                begin
                    op.status = ST_FULL;
                end
                else
                begin
                    op.mem_we = 1'b1;
                    op.addr   = rear_reg;
                    rear_next = idx_next(rear_reg);
                    op.count  = cnt_t'(count_reg + cnt_t'(1));
                end
            end
            ACT_POP:
            begin
                if (count_reg == '0)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.mem_re  = 1'b1;
                    op.addr    = front_reg;
                    front_next = idx_next(front_reg);
                    op.count   = cnt_t'(count_reg - cnt_t'(1));
                end
            end
            ACT_EJECT:
            begin
                if (count_reg == '0)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.mem_re = 1'b1;
                    op.addr   = rear_dec;
                    rear_next = rear_dec;
                    op.count  = cnt_t'(count_reg - cnt_t'(1));
                end
            end
            default:
            begin
                op.status = ST_OK;
            end
        endcase
        count_next = op.count;
    end

    // Pointer and count registers move only on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue held in a RAM ring.
// Instantiates deq_ptr and deq_ram; uses deq_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, action, item_value): one operation per
//   transfer: push front, pop front, inject rear or eject rear.
//   Output channel (out_valid, out_stall, out_value, status, occupancy): one
//   result per operation, in order. out_value holds the removed element for
//   a successful pop or eject and zero otherwise; status reports ok, empty on
//   removal or full on insertion; occupancy is the count after the operation.
// Flow:
//   Push, inject and failed operations load their result into the output
//   registers at the input transfer; with no output stall they can follow
//   every cycle. Pop and eject read the single RAM port at the transfer; as
//   that read is registered, the RAM holds the data and the output registers
//   then take it, and no input is taken while the read is pending.
// Reset: rst_n clears pointers, count and handshake state; the deque is empty
//   and usable straight after reset. No clearing pass is run.
// Stall: while out_stall holds a result, in_stall is raised and nothing is
//   lost; the pending result and the RAM read data stay in place.
module double_ended_queue_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic signed [31:0]          item_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          out_value,
    output logic [1:0]                  status,
    output logic [6:0]                  occupancy
);
    import deq_pkg::*;

    op_t     op;
    logic    in_accept;
    logic    out_free;
    logic    load_direct;
    logic    load_read;
    data_t   wr_data;
    data_t   rd_data;

    logic    rd_pend_reg, rd_pend_next;
    cnt_t    pend_cnt_reg;
    logic    out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg;
    status_t status_reg;
    cnt_t    occ_reg;

    // Handshake: one operation in flight while a RAM read is outstanding.
    assign in_stall    = rd_pend_reg | (out_valid_reg & out_stall);
    assign in_accept   = in_valid & ~in_stall;
    assign out_free    = ~out_valid_reg | ~out_stall;
    assign load_direct = in_accept & ~op.mem_re;
    assign load_read   = rd_pend_reg & out_free;

    assign wr_data = data_t'(unsigned'(item_value));

    deq_ptr u_ptr (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .act    (action_t'(action)),
        .op     (op)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (in_accept & op.mem_we),
        .re    (in_accept & op.mem_re),
        .addr  (op.addr),
        .wdata (wr_data),
        .rdata (rd_data)
    );

    // Next values of the control flags.
    always_comb
    begin
        rd_pend_next = rd_pend_reg;
        if (in_accept & op.mem_re)
        begin
            rd_pend_next = 1'b1;
        end
        else if (load_read)
        begin
            rd_pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_direct | load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept & op.mem_re)
        begin
            pend_cnt_reg <= op.count;
        end
        if (load_direct)
        begin
            out_value_reg <= '0;
            status_reg    <= op.status;
            occ_reg       <= op.count;
        end
        else if (load_read)
        begin
            out_value_reg <= 32'(rd_data);
            status_reg    <= ST_OK;
            occ_reg       <= pend_cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = signed'(out_value_reg);
    assign status    = status_reg;
    assign occupancy = 7'(occ_reg);

    // A removal that reads the RAM is always a successful one.
    a_read_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op.mem_re) |-> (op.status == ST_OK && !op.mem_we))
        else $error("RAM read issued for a failed or writing operation");

    // A RAM read leaves a pending result for the next cycle.
    a_read_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op.mem_re) |=> rd_pend_reg)
        else $error("RAM read without pending result");

    // Failed operations return a zero value; insertions also return zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (out_value == 32'sd0))
        else $error("nonzero value on a failed operation");

    // Occupancy never exceeds the ring size.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= 7'(FULL_CNT)))
        else $error("occupancy beyond deque depth");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the double-ended queue core (double_ended_queue_core).
// It uses deq_pkg for the sizes, the action and status codes and the count type.
// It needs nothing beyond the RTL and runs on its own.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // longest hold-off is HOLD_CYCLES
    localparam int HOLD_CYCLES    = 150;
    localparam int PHASE_ITEMS    = 355;

    typedef struct {
        logic [31:0] value;
        status_t     st;
        cnt_t        occ;
    } deq_result_t;

    // An expectation typed into the directed table replaces the predicted one.
    typedef struct {
        bit          pinned;
        deq_result_t res;
    } pinned_t;

    typedef struct {
        action_t     act;
        logic [31:0] val;
        int          reps;
        bit          pinned;
        logic [31:0] exp_val;
        status_t     exp_st;
        cnt_t        exp_occ;
    } dir_row_t;

    // Directed stimulus. A repeated row adds the repeat index to its value.
    dir_row_t dir_table [23] = '{
        '{ACT_POP,    32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY, 7'd0},
        '{ACT_EJECT,  32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, ST_EMPTY, 7'd0},
        '{ACT_PUSH,   32'h7FFF_FFFF,  1, 1'b1, 32'h0000_0000, ST_OK,    7'd1},
        '{ACT_INJECT, 32'h8000_0000,  1, 1'b1, 32'h0000_0000, ST_OK,    7'd2},
        '{ACT_POP,    32'h0000_0000,  1, 1'b1, 32'h7FFF_FFFF, ST_OK,    7'd1},
        '{ACT_EJECT,  32'h0000_0000,  1, 1'b1, 32'h8000_0000, ST_OK,    7'd0},
        '{ACT_EJECT,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY, 7'd0},
        '{ACT_PUSH,   32'hFFFF_FFFF,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_PUSH,   32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_INJECT, 32'h5555_5555,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_INJECT, 32'hAAAA_AAAA,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_POP,    32'hFFFF_FFFF,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_EJECT,  32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_POP,    32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_EJECT,  32'hFFFF_FFFF,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_POP,    32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY, 7'd0},
        '{ACT_INJECT, 32'h1000_0000, 64, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_PUSH,   32'h1234_5678,  1, 1'b1, 32'h0000_0000, ST_FULL,  7'd64},
        '{ACT_INJECT, 32'h0F0F_0F0F,  1, 1'b1, 32'h0000_0000, ST_FULL,  7'd64},
        '{ACT_POP,    32'h0000_0000,  1, 1'b1, 32'h1000_0000, ST_OK,    7'd63},
        '{ACT_EJECT,  32'h0000_0000,  1, 1'b1, 32'h1000_003F, ST_OK,    7'd62},
        '{ACT_PUSH,   32'h0000_0001,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0},
        '{ACT_INJECT, 32'hFFFF_FFFE,  1, 1'b0, 32'h0000_0000, ST_OK,    7'd0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [31:0] item_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [6:0]         occupancy;

    // Predictor state: the ring, both ends and the element count.
    data_t deque_ring [DEPTH];
    addr_t front_ptr;
    addr_t rear_ptr;
    cnt_t  fill_level;

    deq_result_t pending_results [$];
    pinned_t     pinned_results [$];

    int mismatches;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    bit draining;

    double_ended_queue_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    always #1 clk = ~clk;

    // Apply one operation to the predictor and return the result it gives.
    function automatic deq_result_t apply_op(input action_t op, input logic [31:0] v);
        deq_result_t r;
        r.value = '0;
        r.st    = ST_OK;
        if (op == ACT_PUSH || op == ACT_INJECT)
        begin
            if (fill_level == cnt_t'(DEPTH))
            begin
                r.st = ST_FULL;
            end
            else if (op == ACT_PUSH)
            begin
                front_ptr = addr_t'((int'(front_ptr) + DEPTH - 1) % DEPTH);
                deque_ring[front_ptr] = v;
                fill_level = fill_level + 1'b1;
            end
            else
            begin
                deque_ring[rear_ptr] = v;
                rear_ptr = addr_t'((int'(rear_ptr) + 1) % DEPTH);
                fill_level = fill_level + 1'b1;
            end
        end
        else
        begin
            if (fill_level == '0)
            begin
                r.st = ST_EMPTY;
            end
            else if (op == ACT_POP)
            begin
                r.value = deque_ring[front_ptr];
                front_ptr = addr_t'((int'(front_ptr) + 1) % DEPTH);
                fill_level = fill_level - 1'b1;
            end
            else
            begin
                rear_ptr = addr_t'((int'(rear_ptr) + DEPTH - 1) % DEPTH);
                r.value = deque_ring[rear_ptr];
                fill_level = fill_level - 1'b1;
            end
        end
        r.occ = fill_level;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // Offer one operation, with a random gap first, and wait for its transfer.
    task automatic send_op(input action_t op, input logic [31:0] v, input bit pinned,
                           input deq_result_t res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pinned_results.push_back(pinned_t'{pinned, res});
        in_valid   <= 1'b1;
        action     <= op;
        item_value <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop offering until every expected result has come back.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Check each output transfer, then predict the result of each input transfer.
    always @(posedge clk)
    begin : monitor
        deq_result_t want;
        deq_result_t model;
        pinned_t     pin;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result %h/%0d/%0d with nothing expected",
                                            out_value, status, occupancy));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_value !== want.value)
                        flag_mismatch($sformatf("out_value %h, expected %h",
                                                out_value, want.value));
                    if (status !== want.st)
                        flag_mismatch($sformatf("status %0d, expected %s",
                                                status, want.st.name()));
                    if (occupancy !== want.occ)
                        flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                                occupancy, want.occ));
                end
            end
            if (in_valid && !in_stall)
            begin
                model = apply_op(action_t'(action), item_value);
                if (pinned_results.size() != 0)
                begin
                    pin = pinned_results.pop_front();
                    if (pin.pinned)
                        model = pin.res;
                end
                pending_results.push_back(model);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when requested.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Sender: reset, directed table, then three phases of random operations.
    initial
    begin
        action_t     op;
        logic [31:0] v;
        deq_result_t want;
        int          r;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_PUSH;
        item_value    = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_request  = 0;
        send_idle_pct = 20;
        recv_idle_pct = 46;
        front_ptr     = '0;
        rear_ptr      = '0;
        fill_level    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty and full cases, extremes, wrap of both ends.
        foreach (dir_table[i])
        begin
            for (int k = 0; k < dir_table[i].reps; k++)
            begin
                want.value = dir_table[i].exp_val;
                want.st    = dir_table[i].exp_st;
                want.occ   = dir_table[i].exp_occ;
                send_op(dir_table[i].act, dir_table[i].val + k, dir_table[i].pinned, want);
            end
        end
        pause_until_drained();

        // Random part: sweep between full and empty, with some noise.
        want.value = '0;
        want.st    = ST_OK;
        want.occ   = '0;
        draining   = 1'b1;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 20 : (p == 1) ? 46 : 0;
            recv_idle_pct = (p == 0) ? 46 : (p == 1) ? 20 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (!draining && fill_level == cnt_t'(DEPTH) && $urandom_range(2) == 0)
                    draining = 1'b1;
                else if (draining && fill_level == '0 && $urandom_range(2) == 0)
                    draining = 1'b0;
                r = $urandom_range(99);
                if (r < 10)
                    op = action_t'($urandom_range(3));
                else if ((draining && r < 35) || (!draining && r < 75))
                    op = $urandom_range(1) ? ACT_PUSH : ACT_INJECT;
                else
                    op = $urandom_range(1) ? ACT_POP : ACT_EJECT;
                case ($urandom_range(11))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
                send_op(op, v, 1'b0, want);
                // Long receiver hold-off while items keep coming.
                if ((p == 0 || p == 2) && n == 150)
                    hold_request = HOLD_CYCLES;
                if (p == 1 && n == 200)
                    pause_until_drained();
            end
            pause_until_drained();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
